>>> rtl/relay_channel_pairing_table_top_defines.svh
// assertion macros for the relay channel pairing table
// used by relay_channel_pairing_table_top, no other dependencies
`ifndef RELAY_CHANNEL_PAIRING_TABLE_TOP_DEFINES_SVH
`define RELAY_CHANNEL_PAIRING_TABLE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RCPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RCPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rcpt_pkg.sv
// types and codes shared by the relay channel pairing table
// no dependencies
`default_nettype none

package rcpt_pkg;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_BIND  = 3'd2,
        OP_FWD   = 3'd3,
        OP_SWEEP = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STOPPED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_TOKEN    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_REFUSED  = 3'd5,
        ST_DROPPED  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        REG_ENABLE    = 2'd0,
        REG_MAX_ALLOC = 2'd1,
        REG_IDLE_TO   = 2'd2,
        REG_BIND_TO   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SINGLE,
        S_SCAN
    } t_state;

    // table depth, channel 0 is never issued
    localparam int CHANNEL_COUNT = 1024;

    localparam int EP_W = 48;
    localparam int TOK_W = 64;
    localparam int TIME_W = 32;
    localparam int CHF_W = 10;

    typedef struct packed {
        logic [2:0]        op;
        logic [CHF_W-1:0]  channel;
        logic [TOK_W-1:0]  token;
        logic [EP_W-1:0]   endpoint;
        logic [TIME_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [CHF_W-1:0]  result_channel;
        logic [TOK_W-1:0]  result_token;
        logic [EP_W-1:0]   dest_endpoint;
        logic [CHF_W-1:0]  released_count;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic [1:0]        side;
        logic [TOK_W-1:0]  token;
        logic [EP_W-1:0]   ep_a;
        logic [EP_W-1:0]   ep_b;
        logic [TIME_W-1:0] created;
        logic [TIME_W-1:0] last;
    } t_entry;

    typedef struct packed {
        logic            tok_hit;
        logic            expired;
        logic            fwd_ok;
        logic [EP_W-1:0] fwd_dest;
        logic            bind_ok;
    } t_eval;

endpackage

`default_nettype wire

>>> rtl/rcpt_entry_eval.sv
// shared per-entry unit: token compare, side match, age compare
// depends on rcpt_pkg
`default_nettype none

module rcpt_entry_eval (
    input  rcpt_pkg::t_entry                i_entry,
    input  logic [rcpt_pkg::TOK_W-1:0]      i_token,
    input  logic [rcpt_pkg::EP_W-1:0]       i_endpoint,
    input  logic [rcpt_pkg::TIME_W-1:0]     i_now,
    input  logic [rcpt_pkg::TIME_W-1:0]     i_idle_to,
    input  logic [rcpt_pkg::TIME_W-1:0]     i_bind_to,
    output rcpt_pkg::t_eval                 o_eval,
    output rcpt_pkg::t_entry                o_bound
);

    logic                          match_a;
    logic                          match_b;
    logic                          full;
    logic [rcpt_pkg::TIME_W-1:0]   ref_time;
    logic [rcpt_pkg::TIME_W-1:0]   limit;
    logic [rcpt_pkg::TIME_W-1:0]   age;

    assign match_a  = i_entry.side[0] && (i_entry.ep_a == i_endpoint);
    assign match_b  = i_entry.side[1] && (i_entry.ep_b == i_endpoint);
    assign full     = (i_entry.side == 2'b11);
    // one subtract and compare serves both timeouts
    assign ref_time = full ? i_entry.last : i_entry.created;
    assign limit    = full ? i_idle_to : i_bind_to;
    assign age      = i_now - ref_time;

    always_comb begin
        o_eval.tok_hit  = i_entry.valid && (i_entry.token == i_token);
        o_eval.expired  = i_entry.valid && (age > limit);
        o_eval.fwd_ok   = i_entry.valid &&
                          ((match_a && i_entry.side[1]) || (!match_a && match_b && i_entry.side[0]));
        o_eval.fwd_dest = match_a ? i_entry.ep_b : i_entry.ep_a;
        o_eval.bind_ok  = match_a || match_b || !full;

        o_bound      = i_entry;
        o_bound.last = i_now;
        if (!match_a && !match_b) begin
            if (!i_entry.side[0]) begin
                o_bound.ep_a    = i_endpoint;
                o_bound.side[0] = 1'b1;
            end else if (!i_entry.side[1]) begin
                o_bound.ep_b    = i_endpoint;
                o_bound.side[1] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/relay_channel_pairing_table_top.sv
// relay channel pairing table: top level with sequencer and table memory
// depends on rcpt_pkg, rcpt_entry_eval and relay_channel_pairing_table_top_defines.svh
//
// usage
// - command channel: an item transfer happens at a clock edge with start high and
//   busy low; i_item carries op, channel, token, endpoint and now
// - result channel: o_strobe is high for exactly one cycle with o_result valid;
//   the receiver cannot stall, so every result must be taken in that cycle
// - config port: i_cfg_we, i_cfg_idx, i_cfg_data write one register per edge
//   (0 enable, 1 max allocations, 2 idle timeout, 3 bind timeout)
// - answers: refused requests and unknown ops answer in the cycle after the transfer
//   and leave busy low; free and forward make one table read and answer from S_SINGLE
// - allocate, bind and sweep walk channels 1 .. CHANNEL_COUNT-1 through the one
//   read port of the table memory, one entry per cycle into the shared entry
//   unit; a bind stops early at its token
// - reset: a clearing pass over the whole table wipes valid and side bits,
//   busy stays high meanwhile; writing enable = 0 starts the same pass
// - config is written only while idle: the user must keep to this, the block itself does not enforce it

`default_nettype none
`include "relay_channel_pairing_table_top_defines.svh"

module relay_channel_pairing_table_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rcpt_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output rcpt_pkg::t_out_item o_result,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);

    localparam int CW = $clog2(rcpt_pkg::CHANNEL_COUNT);
    localparam logic [CW-1:0] LAST_CH = CW'(rcpt_pkg::CHANNEL_COUNT - 1);

    // round-robin advance over channels 1 .. CHANNEL_COUNT-1
    function automatic logic [CW-1:0] adv(input logic [CW-1:0] p);
        return (p >= LAST_CH) ? CW'(1) : p + CW'(1);
    endfunction

    rcpt_pkg::t_state    r_state, n_state;

    // latched command
    logic [2:0]                    r_op, n_op;
    logic [CW-1:0]                 r_ch, n_ch;
    logic [rcpt_pkg::TOK_W-1:0]    r_tok, n_tok;
    logic [rcpt_pkg::EP_W-1:0]     r_ep, n_ep;
    logic [rcpt_pkg::TIME_W-1:0]   r_now, n_now;

    // configuration
    logic                          r_en, n_en;
    logic [9:0]                    r_max, n_max;
    logic [31:0]                   r_idle, n_idle;
    logic [31:0]                   r_bindto, n_bindto;

    // table bookkeeping
    logic [CW-1:0]                 r_next, n_next;
    logic [CW-1:0]                 r_count, n_count;

    // scan sequencer
    logic [CW-1:0]                 r_ptr, n_ptr;
    logic [CW-1:0]                 r_left, n_left;
    logic                          r_rvld, n_rvld;
    logic [CW-1:0]                 r_ridx, n_ridx;
    logic                          r_hit, n_hit;
    logic                          r_free_found, n_free_found;
    logic [CW-1:0]                 r_free_idx, n_free_idx;
    logic [CW-1:0]                 r_rel, n_rel;

    // result register
    logic                          r_strobe, n_strobe;
    rcpt_pkg::t_out_item           r_res, n_res;

    // table memory
    rcpt_pkg::t_entry              r_mem [rcpt_pkg::CHANNEL_COUNT];
    rcpt_pkg::t_entry              r_rdata;
    logic                          mem_we;
    logic [CW-1:0]                 mem_wa;
    rcpt_pkg::t_entry              mem_wd;
    logic [CW-1:0]                 rd_addr;

    // sequencer flags
    logic                          in_range;
    logic                          idle_go_scan;
    logic                          idle_go_single;
    logic                          scan_finish;
    logic                          cfg_clear;

    rcpt_pkg::t_eval               ev;
    rcpt_pkg::t_entry              bound;
    rcpt_pkg::t_entry              fresh;

    rcpt_entry_eval u_eval (
        .i_entry    (r_rdata),
        .i_token    (r_tok),
        .i_endpoint (r_ep),
        .i_now      (r_now),
        .i_idle_to  (r_idle),
        .i_bind_to  (r_bindto),
        .o_eval     (ev),
        .o_bound    (bound)
    );

    assign busy     = (r_state != rcpt_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign in_range = (i_item.channel != '0) &&
                      (32'(i_item.channel) < 32'(rcpt_pkg::CHANNEL_COUNT));

    // new pairing written at the end of a successful allocate
    always_comb begin
        fresh         = '0;
        fresh.valid   = 1'b1;
        fresh.token   = r_tok;
        fresh.created = r_now;
        fresh.last    = r_now;
    end

    // datapath and sequencer outputs
    always_comb begin
        n_op         = r_op;
        n_ch         = r_ch;
        n_tok        = r_tok;
        n_ep         = r_ep;
        n_now        = r_now;
        n_en         = r_en;
        n_max        = r_max;
        n_idle       = r_idle;
        n_bindto     = r_bindto;
        n_next       = r_next;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_rvld       = 1'b0;
        n_ridx       = r_ridx;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_rel        = r_rel;
        n_strobe     = 1'b0;
        n_res        = r_res;
        mem_we       = 1'b0;
        mem_wa       = r_ptr;
        mem_wd       = r_rdata;
        rd_addr      = r_ptr;
        idle_go_scan   = 1'b0;
        idle_go_single = 1'b0;
        scan_finish    = 1'b0;
        cfg_clear      = 1'b0;

        unique case (r_state)
            rcpt_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_ptr;
                mem_wd = '0;
                n_ptr  = r_ptr + CW'(1);
            end
            rcpt_pkg::S_IDLE: begin
                rd_addr = CW'(i_item.channel);
                if (start) begin
                    n_op         = i_item.op;
                    n_ch         = CW'(i_item.channel);
                    n_tok        = i_item.token;
                    n_ep         = i_item.endpoint;
                    n_now        = i_item.now;
                    n_hit        = 1'b0;
                    n_free_found = 1'b0;
                    n_rel        = '0;
                    n_left       = LAST_CH;
                    n_ptr        = CW'(1);
                    n_res        = '0;
                    unique case (i_item.op)
                        rcpt_pkg::OP_ALLOC: begin
                            if (!r_en) begin
                                n_strobe     = 1'b1;
                                n_res.status = rcpt_pkg::ST_STOPPED;
                            end else if (32'(r_count) >= 32'(r_max)) begin
                                n_strobe     = 1'b1;
                                n_res.status = rcpt_pkg::ST_FULL;
                            end else if (i_item.token == '0) begin
                                n_strobe     = 1'b1;
                                n_res.status = rcpt_pkg::ST_TOKEN;
                            end else begin
                                // walk starts at the round-robin pointer
                                n_ptr        = r_next;
                                idle_go_scan = 1'b1;
                            end
                        end
                        rcpt_pkg::OP_FREE: begin
                            if (!in_range) begin
                                n_strobe     = 1'b1;
                                n_res.status = rcpt_pkg::ST_NOTFOUND;
                            end else begin
                                idle_go_single = 1'b1;
                            end
                        end
                        rcpt_pkg::OP_BIND: begin
                            if (i_item.token == '0) begin
                                n_strobe     = 1'b1;
                                n_res.status = rcpt_pkg::ST_NOTFOUND;
                            end else begin
                                idle_go_scan = 1'b1;
                            end
                        end
                        rcpt_pkg::OP_FWD: begin
                            if (!in_range) begin
                                n_strobe     = 1'b1;
                                n_res.status = rcpt_pkg::ST_DROPPED;
                            end else begin
                                idle_go_single = 1'b1;
                            end
                        end
                        rcpt_pkg::OP_SWEEP: begin
                            idle_go_scan = 1'b1;
                        end
                        default: begin
                            // unknown op: all-zero result
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            rcpt_pkg::S_SINGLE: begin
                n_strobe = 1'b1;
                n_res    = '0;
                mem_wa   = r_ch;
                if (r_op == rcpt_pkg::OP_FREE) begin
                    if (r_rdata.valid) begin
                        mem_we       = 1'b1;
                        mem_wd.valid = 1'b0;
                        mem_wd.side  = 2'b00;
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                    end else begin
                        n_res.status = rcpt_pkg::ST_NOTFOUND;
                    end
                end else begin
                    if (ev.fwd_ok) begin
                        mem_we              = 1'b1;
                        mem_wd.last         = r_now;
                        n_res.dest_endpoint = ev.fwd_dest;
                    end else begin
                        n_res.status = rcpt_pkg::ST_DROPPED;
                    end
                end
            end
            rcpt_pkg::S_SCAN: begin
                // issue one read per cycle, evaluate the one issued last cycle
                if (r_left != '0) begin
                    rd_addr = r_ptr;
                    n_ptr   = adv(r_ptr);
                    n_left  = r_left - CW'(1);
                    n_rvld  = 1'b1;
                    n_ridx  = r_ptr;
                end
                if (r_rvld) begin
                    unique case (r_op)
                        rcpt_pkg::OP_ALLOC: begin
                            if (ev.tok_hit) begin
                                n_hit = 1'b1;
                            end
                            if (!r_rdata.valid && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_ridx;
                            end
                        end
                        rcpt_pkg::OP_BIND: begin
                            if (ev.tok_hit) begin
                                scan_finish = 1'b1;
                                n_strobe    = 1'b1;
                                n_res       = '0;
                                if (ev.bind_ok) begin
                                    mem_we               = 1'b1;
                                    mem_wa               = r_ridx;
                                    mem_wd               = bound;
                                    n_res.result_channel = 10'(r_ridx);
                                    n_res.result_token   = r_rdata.token;
                                end else begin
                                    n_res.status = rcpt_pkg::ST_REFUSED;
                                end
                            end
                        end
                        default: begin
                            // sweep
                            if (ev.expired) begin
                                mem_we       = 1'b1;
                                mem_wa       = r_ridx;
                                mem_wd.valid = 1'b0;
                                mem_wd.side  = 2'b00;
                                n_rel        = r_rel + CW'(1);
                                if (r_count != '0) begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                    endcase
                end else if (r_left == '0) begin
                    scan_finish = 1'b1;
                    n_strobe    = 1'b1;
                    n_res       = '0;
                    unique case (r_op)
                        rcpt_pkg::OP_ALLOC: begin
                            if (r_hit) begin
                                n_res.status = rcpt_pkg::ST_TOKEN;
                            end else if (r_free_found) begin
                                mem_we               = 1'b1;
                                mem_wa               = r_free_idx;
                                mem_wd               = fresh;
                                n_next               = adv(r_free_idx);
                                n_count              = r_count + CW'(1);
                                n_res.result_channel = 10'(r_free_idx);
                                n_res.result_token   = r_tok;
                            end else begin
                                n_res.status = rcpt_pkg::ST_FULL;
                            end
                        end
                        rcpt_pkg::OP_BIND: begin
                            n_res.status = rcpt_pkg::ST_NOTFOUND;
                        end
                        default: begin
                            n_res.released_count = 10'(r_rel);
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        // configuration writes, only while idle: kept by the user, not enforced here
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcpt_pkg::REG_ENABLE: begin
                    n_en = i_cfg_data[0];
                    if (!i_cfg_data[0]) begin
                        cfg_clear = 1'b1;
                        n_count   = '0;
                        n_ptr     = '0;
                    end
                end
                rcpt_pkg::REG_MAX_ALLOC: n_max    = i_cfg_data[9:0];
                rcpt_pkg::REG_IDLE_TO:   n_idle   = i_cfg_data;
                rcpt_pkg::REG_BIND_TO:   n_bindto = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcpt_pkg::S_CLEAR: begin
                if (r_ptr == LAST_CH) begin
                    n_state = rcpt_pkg::S_IDLE;
                end
            end
            rcpt_pkg::S_IDLE: begin
                if (idle_go_scan) begin
                    n_state = rcpt_pkg::S_SCAN;
                end else if (idle_go_single) begin
                    n_state = rcpt_pkg::S_SINGLE;
                end
            end
            rcpt_pkg::S_SINGLE: begin
                n_state = rcpt_pkg::S_IDLE;
            end
            rcpt_pkg::S_SCAN: begin
                if (scan_finish) begin
                    n_state = rcpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcpt_pkg::S_CLEAR;
            end
        endcase
        if (cfg_clear) begin
            n_state = rcpt_pkg::S_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rcpt_pkg::S_CLEAR;
            r_ptr    <= '0;
            r_left   <= '0;
            r_rvld   <= 1'b0;
            r_strobe <= 1'b0;
            r_en     <= 1'b0;
            r_max    <= 10'd1023;
            r_idle   <= 32'd30000;
            r_bindto <= 32'd10000;
            r_next   <= CW'(1);
            r_count  <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_left   <= n_left;
            r_rvld   <= n_rvld;
            r_strobe <= n_strobe;
            r_en     <= n_en;
            r_max    <= n_max;
            r_idle   <= n_idle;
            r_bindto <= n_bindto;
            r_next   <= n_next;
            r_count  <= n_count;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_tok      <= n_tok;
        r_ep       <= n_ep;
        r_now      <= n_now;
        r_ridx     <= n_ridx;
        r_free_idx <= n_free_idx;
        r_rel      <= n_rel;
        r_res      <= n_res;
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    `RCPT_ASSERT_IMP(a_strobe_not_busy, i_clk, i_rst_n, o_strobe, !busy, "result while busy")
    `RCPT_ASSERT_NXT(a_accept_answers, i_clk, i_rst_n, start && !busy, busy || o_strobe, "transfer dropped")
    `RCPT_ASSERT_IMP(a_next_nonzero, i_clk, i_rst_n, 1'b1, r_next != '0, "channel zero pointer")

endmodule

`default_nettype wire
